>>> hdl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Item structs, status codes, controller commands and state encoding.
// No dependencies.
package ffha_pkg;

   localparam int HEAP_BYTES_DEFAULT   = 4096;
   localparam int HEADER_BYTES_DEFAULT = 32;
   localparam int GRANULE_BYTES        = 8;

   localparam logic REQ_ALLOCATE = 1'b0;
   localparam logic REQ_FREE     = 1'b1;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NO_MEMORY = 2'd1,
      ST_FREED     = 2'd2,
      ST_BAD_ADDR  = 2'd3
   } status_code_type;

   typedef struct packed {
      logic        req_type;
      logic [11:0] req_size;
      logic [11:0] req_addr;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] payload_offset;
   } rsp_item_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_INIT0, OP_LOAD, OP_RD_G, OP_CAP_G, OP_STEP,
      OP_SPLIT, OP_TAKE, OP_WR_G, OP_RD_X, OP_CAP_X, OP_FIX, OP_FSET,
      OP_MERGE_N, OP_NFIX, OP_LDPV, OP_MERGE_P, OP_NOFIX, OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      status_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic kind_free;
      logic bad;
      logic g_start;
      logic g_fit;
      logic g_split;
      logic next_ok;
      logic x_ok;
      logic x_start;
      logic x_free;
      logic prev_ok;
      logic clr_last;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_CLR, S_INIT, S_IDLE, S_RDG, S_CAPG, S_CHK, S_SPLIT, S_TAKE, S_WG,
      S_FXRD, S_FXCAP, S_FXCHK, S_FSET, S_NRD, S_NCAP, S_NCHK, S_MRGN,
      S_NFIX, S_PV, S_PRD, S_PCAP, S_PCHK, S_MRGP, S_NOFIX,
      S_RALLOC, S_ROOM, S_RFREE, S_RBAD
   } ctrl_state_type;

endpackage

>>> hdl/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator with coalescing.
// Joins ffha_controller and ffha_datapath; depends on ffha_pkg.
//
//   Channel   Ports                    Handshake
//   request   start, busy, req         item taken at an edge with start high and busy low
//   result    rsp_strobe, rsp          item shown for one cycle, taken at the edge ending it
//
// After reset the segment table is swept clear, one granule per cycle, and the
// first segment is written; busy stays high throughout.
// An allocate walks the segment chain, each visit a registered read of the
// single table RAM, then refuses, takes or splits the segment and reports.
// A free is shortest on a bad address and longest when it merges with both
// neighbors.
// The result is strobed for one cycle after the work ends; busy drops in that
// same cycle, so the receiver cannot stall the block and never needs to.
module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEFAULT,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffha_pkg::req_item_type req,
   output logic                   rsp_strobe,
   output ffha_pkg::rsp_item_type rsp
);
   import ffha_pkg::*;

   // Commands go from the sequencer to the datapath, status comes back.
   dp_cmd_type    cmd;
   dp_status_type st;

   ffha_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   ffha_datapath #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .st         (st),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // One item in gives exactly one strobe, so two strobes never touch.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held for two cycles");

   // An accepted item keeps the block busy until its result is produced.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("block idle right after accepting an item");

   // Only a grant carries a payload offset.
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.status != ST_ALLOCATED) |-> (rsp.payload_offset == 12'd0))
      else $error("nonzero offset on a result that is not a grant");
endmodule

>>> hdl/ffha_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/ffha_datapath.sv
// Datapath of the heap allocator: segment table RAM, working registers,
// address arithmetic and result register. Depends on ffha_pkg, ffha_ram.
module ffha_datapath #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEFAULT,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffha_pkg::req_item_type req,
   input  ffha_pkg::dp_cmd_type  cmd,
   output ffha_pkg::dp_status_type st,
   output logic                  rsp_strobe,
   output ffha_pkg::rsp_item_type rsp
);
   import ffha_pkg::*;

   localparam int HDR   = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
   localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
   localparam int GI_W  = $clog2(NGRAN);
   localparam int LEN_W = $clog2(HEAP_BYTES + 1);
   localparam int EW    = 3 + LEN_W + GI_W;
   localparam int WW    = ($clog2(HEAP_BYTES) + 3 > 14) ? $clog2(HEAP_BYTES) + 3 : 14;
   localparam logic [WW-1:0] HDR_W   = WW'(HDR);
   localparam logic [WW-1:0] HEAP_W  = WW'(HEAP_BYTES);
   localparam logic [WW-1:0] NGRAN_W = WW'(NGRAN);
   localparam logic [WW-1:0] EIGHT_W = WW'(GRANULE_BYTES);

   // Working registers: the current segment (g) and a neighbor (x).
   logic            kind_ff, bad_ff;
   logic [12:0]     size_ff;
   logic [GI_W-1:0] g_ff, x_ff, link_ff, clr_cnt_ff;
   logic            eg_start_ff, eg_free_ff, eg_hp_ff;
   logic [LEN_W-1:0] eg_len_ff;
   logic [GI_W-1:0] eg_prev_ff;
   logic            ex_start_ff, ex_free_ff, ex_hp_ff, x_ok_ff;
   logic [LEN_W-1:0] ex_len_ff;
   logic [GI_W-1:0] ex_prev_ff;
   logic            rsp_strobe_ff;
   rsp_item_type    rsp_ff;

   logic            we;
   logic [GI_W-1:0] waddr, raddr;
   logic [EW-1:0]   wdata, rdata;

   logic [WW-1:0] g_w, len_w, size_w, pos_g, ng_w, addr_w, off_w;
   logic [GI_W-1:0] ng;
   logic [12:0]   size_in;
   logic          bad_in;

   assign g_w    = WW'(g_ff);
   assign len_w  = WW'(eg_len_ff);
   assign size_w = WW'(size_ff);
   assign pos_g  = (g_w << 3) + HDR_W + len_w;
   assign ng_w   = ((g_w << 3) + HDR_W + size_w) >> 3;
   assign ng     = GI_W'(ng_w);
   assign addr_w = WW'(req.req_addr);
   assign off_w  = addr_w - HDR_W;
   assign size_in = 13'(({1'b0, req.req_size} + 13'd7) & ~13'd7);
   assign bad_in = (addr_w < HDR_W) || (off_w[2:0] != 3'd0) || ((off_w >> 3) >= NGRAN_W);

   always_comb begin
      st.kind_free = kind_ff;
      st.bad       = bad_ff;
      st.g_start   = eg_start_ff;
      st.g_fit     = eg_free_ff && (len_w >= size_w);
      st.g_split   = (len_w > size_w + HDR_W + EIGHT_W) && (ng_w < NGRAN_W);
      st.next_ok   = pos_g < HEAP_W;
      st.x_ok      = x_ok_ff;
      st.x_start   = ex_start_ff;
      st.x_free    = ex_free_ff;
      st.prev_ok   = eg_hp_ff && (WW'(eg_prev_ff) < NGRAN_W);
      st.clr_last  = &clr_cnt_ff;
   end

   // Table write port and read address.
   always_comb begin
      we    = 1'b0;
      waddr = g_ff;
      wdata = '0;
      raddr = g_ff;
      case (cmd.op)
         OP_CLR: begin
            we    = 1'b1;
            waddr = clr_cnt_ff;
         end
         OP_INIT0: begin
            we    = 1'b1;
            waddr = '0;
            wdata = {1'b1, 1'b1, LEN_W'(HEAP_BYTES - HDR), 1'b0, GI_W'(0)};
         end
         OP_SPLIT: begin
            we    = 1'b1;
            waddr = ng;
            wdata = {1'b1, 1'b1, LEN_W'(len_w - size_w - HDR_W), 1'b1, g_ff};
         end
         OP_WR_G: begin
            we    = 1'b1;
            wdata = {eg_start_ff, eg_free_ff, eg_len_ff, eg_hp_ff, eg_prev_ff};
         end
         OP_RD_X: raddr = x_ff;
         OP_FIX: begin
            we    = 1'b1;
            waddr = x_ff;
            wdata = {ex_start_ff, ex_free_ff, ex_len_ff, 1'b1, link_ff};
         end
         OP_MERGE_N: begin
            we    = 1'b1;
            waddr = x_ff;
            wdata = {1'b0, 1'b0, ex_len_ff, 1'b0, ex_prev_ff};
         end
         OP_MERGE_P: begin
            we    = 1'b1;
            waddr = x_ff;
            wdata = {ex_start_ff, ex_free_ff,
                     LEN_W'(WW'(ex_len_ff) + len_w + HDR_W), ex_hp_ff, ex_prev_ff};
         end
         default: ;
      endcase
   end

   ffha_ram #(.WIDTH(EW), .DEPTH(1 << GI_W)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.op == OP_RESP);
         if (cmd.op == OP_CLR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
      case (cmd.op)
         OP_LOAD: begin
            kind_ff <= req.req_type;
            size_ff <= size_in;
            bad_ff  <= bad_in;
            g_ff    <= (req.req_type == REQ_FREE) ? GI_W'(off_w >> 3) : '0;
         end
         OP_CAP_G: {eg_start_ff, eg_free_ff, eg_len_ff, eg_hp_ff, eg_prev_ff} <= rdata;
         OP_CAP_X: {ex_start_ff, ex_free_ff, ex_len_ff, ex_hp_ff, ex_prev_ff} <= rdata;
         OP_STEP:  g_ff <= GI_W'(pos_g >> 3);
         OP_SPLIT: begin
            x_ff       <= GI_W'(pos_g >> 3);
            x_ok_ff    <= pos_g < HEAP_W;
            link_ff    <= ng;
            eg_len_ff  <= LEN_W'(size_w);
            eg_free_ff <= 1'b0;
         end
         OP_TAKE: begin
            eg_free_ff <= 1'b0;
            x_ok_ff    <= 1'b0;
         end
         OP_FSET: begin
            eg_free_ff <= 1'b1;
            x_ff       <= GI_W'(pos_g >> 3);
            x_ok_ff    <= pos_g < HEAP_W;
         end
         OP_MERGE_N: eg_len_ff <= LEN_W'(len_w + WW'(ex_len_ff) + HDR_W);
         OP_NFIX: begin
            x_ff    <= GI_W'(pos_g >> 3);
            x_ok_ff <= pos_g < HEAP_W;
            link_ff <= g_ff;
         end
         OP_LDPV: x_ff <= eg_prev_ff;
         OP_MERGE_P: begin
            link_ff     <= x_ff;
            x_ff        <= GI_W'(pos_g >> 3);
            x_ok_ff     <= pos_g < HEAP_W;
            eg_start_ff <= 1'b0;
            eg_free_ff  <= 1'b0;
            eg_hp_ff    <= 1'b0;
         end
         OP_NOFIX: x_ok_ff <= 1'b0;
         OP_RESP: begin
            rsp_ff.status         <= cmd.code;
            rsp_ff.payload_offset <= (cmd.code == ST_ALLOCATED) ?
                                     12'((g_w << 3) + HDR_W) : 12'd0;
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;
endmodule

>>> hdl/ffha_controller.sv
// Sequencer of the heap allocator: table clearing, first-fit walk,
// split, and free with coalescing. Depends on ffha_pkg.
module ffha_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ffha_pkg::dp_status_type st,
   output ffha_pkg::dp_cmd_type    cmd,
   output logic                    busy
);
   import ffha_pkg::*;

   ctrl_state_type state_ff, state_in, ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_CLR:   if (st.clr_last) state_in = S_INIT;
         S_INIT:  state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_RDG;
         S_RDG:   state_in = S_CAPG;
         S_CAPG:  state_in = S_CHK;
         S_CHK: begin
            if (st.kind_free) begin
               state_in = (st.bad || !st.g_start) ? S_RBAD : S_FSET;
            end else if (!st.g_start) begin
               state_in = S_ROOM;
            end else if (st.g_fit) begin
               state_in = st.g_split ? S_SPLIT : S_TAKE;
            end else begin
               state_in = st.next_ok ? S_RDG : S_ROOM;
            end
         end
         S_SPLIT, S_TAKE, S_MRGP, S_NOFIX: state_in = S_WG;
         S_WG: begin
            state_in = S_FXRD;
            ret_in   = st.kind_free ? S_RFREE : S_RALLOC;
         end
         S_FXRD:  state_in = st.x_ok ? S_FXCAP : ret_ff;
         S_FXCAP: state_in = S_FXCHK;
         S_FXCHK: state_in = ret_ff;
         S_FSET:  state_in = S_NRD;
         S_NRD:   state_in = st.x_ok ? S_NCAP : S_PV;
         S_NCAP:  state_in = S_NCHK;
         S_NCHK:  state_in = (st.x_start && st.x_free) ? S_MRGN : S_PV;
         S_MRGN:  state_in = S_NFIX;
         S_NFIX: begin
            state_in = S_FXRD;
            ret_in   = S_PV;
         end
         S_PV:    state_in = st.prev_ok ? S_PRD : S_NOFIX;
         S_PRD:   state_in = S_PCAP;
         S_PCAP:  state_in = S_PCHK;
         S_PCHK:  state_in = (st.x_start && st.x_free) ? S_MRGP : S_NOFIX;
         S_RALLOC, S_ROOM, S_RFREE, S_RBAD: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = OP_NONE;
      cmd.code = ST_ALLOCATED;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_CLR:   cmd.op = OP_CLR;
         S_INIT:  cmd.op = OP_INIT0;
         S_IDLE:  if (start) cmd.op = OP_LOAD;
         S_RDG:   cmd.op = OP_RD_G;
         S_CAPG:  cmd.op = OP_CAP_G;
         S_CHK: begin
            if (!st.kind_free && st.g_start && !st.g_fit && st.next_ok) begin
               cmd.op = OP_STEP;
            end
         end
         S_SPLIT: cmd.op = OP_SPLIT;
         S_TAKE:  cmd.op = OP_TAKE;
         S_WG:    cmd.op = OP_WR_G;
         S_FXRD, S_NRD: if (st.x_ok) cmd.op = OP_RD_X;
         S_PRD:   cmd.op = OP_RD_X;
         S_FXCAP, S_NCAP, S_PCAP: cmd.op = OP_CAP_X;
         S_FXCHK: if (st.x_start) cmd.op = OP_FIX;
         S_FSET:  cmd.op = OP_FSET;
         S_MRGN:  cmd.op = OP_MERGE_N;
         S_NFIX:  cmd.op = OP_NFIX;
         S_PV:    if (st.prev_ok) cmd.op = OP_LDPV;
         S_MRGP:  cmd.op = OP_MERGE_P;
         S_NOFIX: cmd.op = OP_NOFIX;
         S_RALLOC: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_ALLOCATED;
         end
         S_ROOM: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_NO_MEMORY;
         end
         S_RFREE: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_FREED;
         end
         S_RBAD: begin
            cmd.op   = OP_RESP;
            cmd.code = ST_BAD_ADDR;
         end
         default: ;
      endcase
   end
endmodule

>>> tb/testbench.sv
// Self-checking testbench for first_fit_heap_allocator_unit.
// Holds a heap bookkeeping model in a small scoreboard class; depends on ffha_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import ffha_pkg::*;

   localparam int HEAP      = HEAP_BYTES_DEFAULT;
   localparam int HDR       = (HEADER_BYTES_DEFAULT + GRANULE_BYTES - 1) / GRANULE_BYTES
                              * GRANULE_BYTES;
   localparam int NGRAN     = HEAP / GRANULE_BYTES;
   localparam int IDLE_MAX  = 20000;  // cycles with no item moving in either direction
   localparam int TAIL      = 40;

   // The scoreboard keeps its own copy of the segment table. Each accepted
   // request is applied to it at once, and the outcome waits in a queue
   // until the block strobes its result.
   class heap_scoreboard;
      bit                  head_mark [NGRAN];
      bit                  free_mark [NGRAN];
      bit [11:0]           pay_len   [NGRAN];
      bit [8:0]            prev_gran [NGRAN];
      bit                  has_prev  [NGRAN];
      rsp_item_type        awaited[$];
      int                  mismatches;

      function new();
         foreach (head_mark[i]) begin
            head_mark[i] = 0;
            free_mark[i] = 0;
            pay_len[i]   = 0;
            prev_gran[i] = 0;
            has_prev[i]  = 0;
         end
         head_mark[0] = 1;
         free_mark[0] = 1;
         pay_len[0]   = 12'(HEAP - HDR);
         mismatches   = 0;
      endfunction

      // Granule of the segment that follows g, or NGRAN at the end of the chain.
      function int follower(int g);
         int p;
         p = g * GRANULE_BYTES + HDR + pay_len[g];
         if (p >= HEAP) return NGRAN;
         p = p / GRANULE_BYTES;
         if (p >= NGRAN || !head_mark[p]) return NGRAN;
         return p;
      endfunction

      function rsp_item_type allocate(int size);
         rsp_item_type r;
         int g, ng, after;
         g    = 0;
         size = (size + 7) & ~7;
         while (g < NGRAN && head_mark[g]) begin
            if (free_mark[g] && pay_len[g] >= size) begin
               if (pay_len[g] > size + HDR + 8) begin
                  ng = (g * GRANULE_BYTES + HDR + size) / GRANULE_BYTES;
                  if (ng < NGRAN) begin
                     after         = follower(g);
                     head_mark[ng] = 1;
                     free_mark[ng] = 1;
                     pay_len[ng]   = 12'(pay_len[g] - size - HDR);
                     prev_gran[ng] = 9'(g);
                     has_prev[ng]  = 1;
                     if (after < NGRAN) begin
                        prev_gran[after] = 9'(ng);
                        has_prev[after]  = 1;
                     end
                     pay_len[g] = 12'(size);
                  end
               end
               free_mark[g]     = 0;
               r.status         = ST_ALLOCATED;
               r.payload_offset = 12'(g * GRANULE_BYTES + HDR);
               return r;
            end
            g = follower(g);
         end
         r.status         = ST_NO_MEMORY;
         r.payload_offset = '0;
         return r;
      endfunction

      function rsp_item_type release_segment(int addr);
         rsp_item_type r;
         int g, nx, pv, after;
         r.payload_offset = '0;
         r.status         = ST_BAD_ADDR;
         if (addr < HDR || ((addr - HDR) % GRANULE_BYTES) != 0) return r;
         g = (addr - HDR) / GRANULE_BYTES;
         if (g >= NGRAN || !head_mark[g]) return r;
         free_mark[g] = 1;
         // Absorb a free successor first.
         nx = follower(g);
         if (nx < NGRAN && free_mark[nx]) begin
            pay_len[g]    = 12'(pay_len[g] + pay_len[nx] + HDR);
            head_mark[nx] = 0;
            free_mark[nx] = 0;
            has_prev[nx]  = 0;
            after = follower(g);
            if (after < NGRAN) begin
               prev_gran[after] = 9'(g);
               has_prev[after]  = 1;
            end
         end
         // Then fold into a free predecessor.
         if (has_prev[g]) begin
            pv = prev_gran[g];
            if (head_mark[pv] && free_mark[pv]) begin
               after        = follower(g);
               pay_len[pv]  = 12'(pay_len[pv] + pay_len[g] + HDR);
               head_mark[g] = 0;
               free_mark[g] = 0;
               has_prev[g]  = 0;
               if (after < NGRAN) begin
                  prev_gran[after] = 9'(pv);
                  has_prev[after]  = 1;
               end
            end
         end
         r.status = ST_FREED;
         return r;
      endfunction

      function rsp_item_type note_request(req_item_type q);
         rsp_item_type r;
         if (q.req_type == REQ_ALLOCATE) r = allocate(q.req_size);
         else                            r = release_segment(q.req_addr);
         awaited.push_back(r);
         return r;
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result status=%0d offset=%0d",
                        $time, got.status, got.payload_offset);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.payload_offset !== want.payload_offset) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result mismatch: expected status=%0d offset=%0d, %s%0d offset=%0d",
                        $time, want.status, want.payload_offset, "got status=",
                        got.status, got.payload_offset);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req;
   logic         rsp_strobe;
   rsp_item_type rsp;

   heap_scoreboard sb;
   int             idle_cycles;
   int             gap_percent;
   int             live_offsets[$];   // payload offsets currently granted
   int             spent_offsets[$];  // offsets freed at some point, for double frees

   first_fit_heap_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Result monitor and watchdog. Outputs are read at the edge, before any
   // update scheduled at that edge lands. Requests are noted by the driving
   // task; the expected queue is in order, so a result and a new request at
   // the same edge never disturb each other.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) sb.check_result(rsp);
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Presents one item and holds it until the block takes it. The item is
   // noted in the scoreboard at the accepting edge, and a grant is kept so
   // that later frees can hit live segments.
   task automatic send_item(input logic kind, input int size, input int addr);
      req_item_type q;
      rsp_item_type r;
      int           gap;
      q.req_type = kind;
      q.req_size = size[11:0];
      q.req_addr = addr[11:0];
      start <= 1'b1;
      req   <= q;
      do @(posedge clock); while (busy);
      // The request went in at this edge.
      r = sb.note_request(q);
      if (kind == REQ_ALLOCATE && r.status == ST_ALLOCATED)
         live_offsets.push_back(r.payload_offset);
      gap = 0;
      while ($urandom_range(99) < gap_percent && gap < 30) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic alloc_item(input int size);
      send_item(REQ_ALLOCATE, size, $urandom_range(4095));
   endtask

   task automatic free_item(input int addr);
      send_item(REQ_FREE, $urandom_range(4095), addr);
   endtask

   // Frees a live segment picked at random and remembers it as spent.
   task automatic free_live();
      int k, a;
      k = $urandom_range(live_offsets.size() - 1);
      a = live_offsets[k];
      live_offsets.delete(k);
      spent_offsets.push_back(a);
      if (spent_offsets.size() > 64) void'(spent_offsets.pop_front());
      free_item(a);
   endtask

   task automatic random_phase(input int count, input int pct);
      int pick;
      gap_percent = pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            // Mostly small sizes; now and then a large one or a full-range value.
            if ($urandom_range(9) == 0) alloc_item($urandom_range(4095));
            else if ($urandom_range(9) == 0) alloc_item($urandom_range(1500));
            else alloc_item($urandom_range(160));
         end else if (pick < 88 && live_offsets.size() > 0) begin
            free_live();
         end else if (pick < 94 && spent_offsets.size() > 0) begin
            // A double free, or a stale header that a merge has absorbed.
            free_item(spent_offsets[$urandom_range(spent_offsets.size() - 1)]);
         end else begin
            free_item($urandom_range(4095));
         end
      end
   endtask

   initial begin
      sb          = new();
      gap_percent = 0;
      idle_cycles = 0;
      reset = 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its table after reset with busy
      // high, so the first item simply waits for it.
      alloc_item(0);            // zero size takes the first free segment and splits it
      alloc_item(4095);         // no fit in what remains
      alloc_item(1);            // rounds up to one granule
      alloc_item(24);
      free_item(0);             // below the header size
      free_item(37);            // off a granule boundary
      free_item(4095);          // all ones, not a segment start
      free_item(live_offsets[1]);   // middle segment, neighbors in use
      free_item(live_offsets[1]);   // double free of the same segment
      free_item(live_offsets[2]);   // merges with the free successor and the free previous segment
      free_item(live_offsets[2]);   // its header was absorbed: rejected as stale
      free_item(live_offsets[0]);   // merges with the free successor
      live_offsets.delete();
      alloc_item(HEAP - 2 * HDR - 8);  // remainder too small to split off
      alloc_item(8);                   // heap exhausted
      free_item(HDR);                  // whole heap back to a single segment
      alloc_item(HEAP - HDR);          // exact fit of the whole heap
      free_item(HDR);
      live_offsets.delete();
      alloc_item(2048);
      alloc_item(1024);
      alloc_item(2730);                // 0xAAA, no fit
      alloc_item(1365);                // 0x555

      random_phase(150, 19);
      random_phase(150, 83);
      random_phase(150, 0);

      start <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
